>>> rtl/assert_macros.svh
// Assertion macros used by the framer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication, checked on clk, off during rst
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk, off during rst
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/tfb_pkg.sv
// Types, constants and CRC function for the telemetry framer
`default_nettype none
package tfb_pkg;

  localparam logic [7:0]  MAGIC_A  = 8'hC3;
  localparam logic [7:0]  MAGIC_B  = 8'h3C;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic [7:0] VERSION_RESET = 8'd7;
  localparam logic [7:0] TYPE_RESET    = 8'd1;

  // register indexes of the write port
  localparam logic REG_PROTOCOL_VERSION = 1'b0;
  localparam logic REG_FRAME_TYPE       = 1'b1;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        first_byte;
    logic        last_byte;
    logic [15:0] payload_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
  } out_item_t;

  // one byte handed from the sequencer to the output register
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } emit_t;

  // position inside the output sequence of one request
  typedef enum logic [3:0] {
    PH_HDR0   = 4'd0,
    PH_HDR1   = 4'd1,
    PH_HDR2   = 4'd2,
    PH_HDR3   = 4'd3,
    PH_HDR4   = 4'd4,
    PH_HDR5   = 4'd5,
    PH_HDR6   = 4'd6,
    PH_HDR7   = 4'd7,
    PH_DATA   = 4'd8,
    PH_CRC_LO = 4'd9,
    PH_CRC_HI = 4'd10
  } phase_t;

  // CRC-16/CCITT-FALSE, one byte, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> rtl/telemetry_frame_builder_crc16.sv
// A request is held in the sequencer stage and its bytes are registered onto out_data.
// Throughput: one output byte per cycle unless the output stalls; a request yields
//   1 byte for a plain byte, 9 with a header, 3 with the CRC trailer, 11 with both,
//   none for a byte outside a frame. The next request is taken as the last byte leaves.
// Reset (rst, synchronous): clears frame state, CRC to 0xFFFF, sequence to 0,
//   version to 7 and frame type to 1.
`default_nettype none
module telemetry_frame_builder_crc16 (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire tfb_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output tfb_pkg::out_item_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [7:0]         cfg_data
);

  logic [7:0]     protocol_version;
  logic [7:0]     frame_type;
  logic           out_free;
  tfb_pkg::emit_t emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_version <= tfb_pkg::VERSION_RESET;
      frame_type       <= tfb_pkg::TYPE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tfb_pkg::REG_PROTOCOL_VERSION: protocol_version <= cfg_data;
        tfb_pkg::REG_FRAME_TYPE:       frame_type       <= cfg_data;
        default:                       protocol_version <= protocol_version;
      endcase
    end
  end

  tfb_seq u_seq (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data          (in_data),
    .protocol_version (protocol_version),
    .frame_type       (frame_type),
    .out_free         (out_free),
    .emit             (emit)
  );

  tfb_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .emit      (emit),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

>>> rtl/tfb_out_reg.sv
// Output register for framed bytes
`default_nettype none
module tfb_out_reg (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tfb_pkg::emit_t     emit,
  output logic                    out_free,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output tfb_pkg::out_item_t      out_data
);

  logic out_valid_next;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    if (emit.valid) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_data <= emit.item;
    end
  end

endmodule
`default_nettype wire

>>> rtl/tfb_seq.sv
// Request holding stage, byte sequencer and CRC/sequence state
`default_nettype none
`include "assert_macros.svh"
module tfb_seq (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire tfb_pkg::in_item_t  in_data,
  input  wire logic [7:0]         protocol_version,
  input  wire logic [7:0]         frame_type,
  input  wire logic               out_free,
  output tfb_pkg::emit_t          emit
);

  tfb_pkg::in_item_t item;
  logic              stage_valid;
  logic              stage_valid_next;
  tfb_pkg::phase_t   state;
  tfb_pkg::phase_t   state_next;
  logic [15:0]       crc;
  logic [15:0]       crc_next;
  logic [15:0]       frame_sequence;
  logic [15:0]       frame_sequence_next;
  logic              inside_frame;
  logic              inside_frame_next;

  logic        load;
  logic        done;
  logic [7:0]  hdr_byte;
  logic [15:0] crc_base;

  assign in_ready = !stage_valid || done;
  assign load     = in_valid && in_ready;

  always_comb begin
    case (state)
      tfb_pkg::PH_HDR0: hdr_byte = tfb_pkg::MAGIC_A;
      tfb_pkg::PH_HDR1: hdr_byte = tfb_pkg::MAGIC_B;
      tfb_pkg::PH_HDR2: hdr_byte = protocol_version;
      tfb_pkg::PH_HDR3: hdr_byte = frame_type;
      tfb_pkg::PH_HDR4: hdr_byte = frame_sequence[7:0];
      tfb_pkg::PH_HDR5: hdr_byte = frame_sequence[15:8];
      tfb_pkg::PH_HDR6: hdr_byte = item.payload_length[7:0];
      tfb_pkg::PH_HDR7: hdr_byte = item.payload_length[15:8];
      default:          hdr_byte = item.payload_byte;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    emit           = '0;
    done           = 1'b0;
    if (stage_valid) begin
      case (state)
        tfb_pkg::PH_HDR0, tfb_pkg::PH_HDR1, tfb_pkg::PH_HDR2, tfb_pkg::PH_HDR3,
        tfb_pkg::PH_HDR4, tfb_pkg::PH_HDR5, tfb_pkg::PH_HDR6, tfb_pkg::PH_HDR7: begin
          emit.valid         = out_free;
          emit.item.out_byte = hdr_byte;
        end
        tfb_pkg::PH_DATA: begin
          if (!inside_frame) begin
            // stray byte outside a frame: dropped, no result
            done = 1'b1;
          end else begin
            emit.valid         = out_free;
            emit.item.out_byte = item.payload_byte;
            emit.item.run_last = !item.last_byte;
            done               = out_free && !item.last_byte;
          end
        end
        tfb_pkg::PH_CRC_LO: begin
          emit.valid         = out_free;
          emit.item.out_byte = crc[7:0];
        end
        tfb_pkg::PH_CRC_HI: begin
          emit.valid          = out_free;
          emit.item.out_byte  = crc[15:8];
          emit.item.run_last  = 1'b1;
          emit.item.frame_end = 1'b1;
          done                = out_free;
        end
        default: begin
          done = 1'b1;
        end
      endcase
    end
  end

  // next phase
  always_comb begin
    state_next = state;
    if (load) begin
      state_next = in_data.first_byte ? tfb_pkg::PH_HDR0 : tfb_pkg::PH_DATA;
    end else if (emit.valid && !done) begin
      case (state)
        tfb_pkg::PH_HDR0:   state_next = tfb_pkg::PH_HDR1;
        tfb_pkg::PH_HDR1:   state_next = tfb_pkg::PH_HDR2;
        tfb_pkg::PH_HDR2:   state_next = tfb_pkg::PH_HDR3;
        tfb_pkg::PH_HDR3:   state_next = tfb_pkg::PH_HDR4;
        tfb_pkg::PH_HDR4:   state_next = tfb_pkg::PH_HDR5;
        tfb_pkg::PH_HDR5:   state_next = tfb_pkg::PH_HDR6;
        tfb_pkg::PH_HDR6:   state_next = tfb_pkg::PH_HDR7;
        tfb_pkg::PH_HDR7:   state_next = tfb_pkg::PH_DATA;
        tfb_pkg::PH_DATA:   state_next = tfb_pkg::PH_CRC_LO;
        tfb_pkg::PH_CRC_LO: state_next = tfb_pkg::PH_CRC_HI;
        default:            state_next = state;
      endcase
    end
  end

  always_comb begin
    stage_valid_next = stage_valid;
    if (load) begin
      stage_valid_next = 1'b1;
    end else if (done) begin
      stage_valid_next = 1'b0;
    end
  end

  // frame state: header restarts the CRC, high CRC byte closes the frame
  assign crc_base = (state == tfb_pkg::PH_HDR0) ? tfb_pkg::CRC_INIT : crc;

  always_comb begin
    crc_next            = crc;
    frame_sequence_next = frame_sequence;
    inside_frame_next   = inside_frame;
    if (emit.valid) begin
      case (state)
        tfb_pkg::PH_CRC_LO: begin
          crc_next = crc;
        end
        tfb_pkg::PH_CRC_HI: begin
          crc_next            = tfb_pkg::CRC_INIT;
          frame_sequence_next = frame_sequence + 16'd1;
          inside_frame_next   = 1'b0;
        end
        default: begin
          crc_next = tfb_pkg::crc_byte(crc_base, emit.item.out_byte);
          if (state == tfb_pkg::PH_HDR0) begin
            inside_frame_next = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid    <= 1'b0;
      state          <= tfb_pkg::PH_DATA;
      crc            <= tfb_pkg::CRC_INIT;
      frame_sequence <= '0;
      inside_frame   <= 1'b0;
    end else begin
      stage_valid    <= stage_valid_next;
      state          <= state_next;
      crc            <= crc_next;
      frame_sequence <= frame_sequence_next;
      inside_frame   <= inside_frame_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= in_data;
    end
  end

  `ASSERT_IMPL(a_frame_end_last, emit.valid && emit.item.frame_end, emit.item.run_last, "frame end without run_last")
  `ASSERT_IMPL(a_crc_in_frame, stage_valid && (state == tfb_pkg::PH_CRC_LO || state == tfb_pkg::PH_CRC_HI), inside_frame, "CRC phase outside a frame")
  `ASSERT_NEXT(a_close_frame, emit.valid && state == tfb_pkg::PH_CRC_HI, !inside_frame && crc == tfb_pkg::CRC_INIT, "frame not closed after CRC")

endmodule
`default_nettype wire

>>> tb/tb_telemetry_frame_builder_crc16.sv
// Self-checking testbench for the telemetry frame builder with CRC-16 trailer
module tb_telemetry_frame_builder_crc16;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SETTLE_CYCLES    = 16;
  localparam int unsigned RANDOM_REQUESTS  = 390;
  localparam int unsigned QUIET_TAIL_START = 330;
  localparam int unsigned MAX_REPORTS      = 10;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  tfb_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  tfb_pkg::out_item_t out_data;
  logic               cfg_we;
  logic               cfg_index;
  logic [7:0]         cfg_data;

  telemetry_frame_builder_crc16 dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // framer state as the testbench sees it
  logic [7:0]  proto_version = tfb_pkg::VERSION_RESET;
  logic [7:0]  frame_kind    = tfb_pkg::TYPE_RESET;
  logic [15:0] frame_crc     = tfb_pkg::CRC_INIT;
  logic [15:0] frame_seq     = 16'h0000;
  bit          frame_open    = 1'b0;

  tfb_pkg::out_item_t expected_bytes[$];
  int unsigned requests_with_output = 0;
  int unsigned mismatch_count = 0;
  int unsigned byte_index = 0;

  bit          rx_stall_on = 1'b0;
  bit          tx_gaps_on = 1'b0;
  int unsigned rx_hold_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #60ms;
    $display("** telemetry_frame_builder_crc16: FAILED **");
    $finish;
  end

  // bit-serial CCITT update, data MSB first
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] d);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ d[i];
      c = {c[14:0], 1'b0} ^ (fb ? tfb_pkg::CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic void predict_request(input tfb_pkg::in_item_t req);
    tfb_pkg::out_item_t run[$];
    logic [7:0]         hdr[8];
    if (req.first_byte) begin
      // a new header drops any open frame without a trailer
      hdr = '{tfb_pkg::MAGIC_A, tfb_pkg::MAGIC_B, proto_version, frame_kind,
              frame_seq[7:0], frame_seq[15:8],
              req.payload_length[7:0], req.payload_length[15:8]};
      frame_crc = tfb_pkg::CRC_INIT;
      frame_open = 1'b1;
      foreach (hdr[i]) begin
        run.push_back('{out_byte: hdr[i], run_last: 1'b0, frame_end: 1'b0});
        frame_crc = crc16_step(frame_crc, hdr[i]);
      end
    end
    if (frame_open) begin
      run.push_back('{out_byte: req.payload_byte, run_last: 1'b0, frame_end: 1'b0});
      frame_crc = crc16_step(frame_crc, req.payload_byte);
      if (req.last_byte) begin
        run.push_back('{out_byte: frame_crc[7:0], run_last: 1'b0, frame_end: 1'b0});
        run.push_back('{out_byte: frame_crc[15:8], run_last: 1'b0, frame_end: 1'b1});
        frame_seq = frame_seq + 16'd1;
        frame_crc = tfb_pkg::CRC_INIT;
        frame_open = 1'b0;
      end
      run[run.size() - 1].run_last = 1'b1;
      requests_with_output++;
    end
    foreach (run[i]) expected_bytes.push_back(run[i]);
  endfunction

  function automatic tfb_pkg::in_item_t make_req(input logic [7:0] b, input bit first,
                                                 input bit last, input logic [15:0] len);
    tfb_pkg::in_item_t r;
    r.payload_byte = b;
    r.first_byte = first;
    r.last_byte = last;
    r.payload_length = len;
    return r;
  endfunction

  function automatic void flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("mismatch: %s", what);
  endfunction

  // output side: compare every accepted byte with the oldest expectation
  always @(posedge clk) begin
    tfb_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        flag_mismatch($sformatf("output %0d: unexpected byte %02h run_last %0b frame_end %0b",
                                byte_index, out_data.out_byte, out_data.run_last,
                                out_data.frame_end));
      end else begin
        want = expected_bytes.pop_front();
        if (out_data.out_byte !== want.out_byte || out_data.run_last !== want.run_last ||
            out_data.frame_end !== want.frame_end)
          flag_mismatch($sformatf({"output %0d: expected byte %02h run_last %0b frame_end %0b,",
                                   " got byte %02h run_last %0b frame_end %0b"},
                                  byte_index, want.out_byte, want.run_last, want.frame_end,
                                  out_data.out_byte, out_data.run_last, out_data.frame_end));
      end
      byte_index++;
    end
  end

  // output ready: long hold when asked, random stall bursts while stalls are on, else high
  initial begin : result_sink
    int unsigned idle_left;
    idle_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        out_ready <= 1'b0;
        rx_hold_cycles--;
      end else if (idle_left > 0) begin
        out_ready <= 1'b0;
        idle_left--;
      end else if (rx_stall_on && $urandom_range(0, 99) < 10) begin
        out_ready <= 1'b0;
        idle_left = $urandom_range(0, 18);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // returns at the edge where the request was taken; valid stays up until the next call or drain
  task automatic send_request(input tfb_pkg::in_item_t req);
    @(negedge clk);
    if (tx_gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(req);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk);
    // a stray byte can still occupy the stage after the last result
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == tfb_pkg::REG_PROTOCOL_VERSION) proto_version = val;
    else frame_kind = val;
  endtask

  task automatic send_frame(input int unsigned n, input logic [15:0] declared,
                            input bit complete);
    for (int unsigned i = 0; i < n; i++)
      send_request(make_req(8'($urandom), i == 0, complete && i == n - 1,
                            i == 0 ? declared : 16'($urandom)));
  endtask

  task automatic test_reset_defaults();
    rx_stall_on = 1'b0;
    tx_gaps_on = 1'b0;
    send_request(make_req(8'h00, 1'b1, 1'b1, 16'd1));
    send_request(make_req(8'hFF, 1'b1, 1'b1, 16'd1));
  endtask

  task automatic test_multi_byte_frame();
    rx_stall_on = 1'b1;
    tx_gaps_on = 1'b1;
    send_request(make_req(8'hFF, 1'b1, 1'b0, 16'd65525));
    send_request(make_req(8'h00, 1'b0, 1'b0, 16'hFFFF));
    send_request(make_req(8'h80, 1'b0, 1'b1, 16'h0000));
    // lengths outside the legal range go into the header untouched
    send_request(make_req(8'h01, 1'b1, 1'b0, 16'hFFFF));
    send_request(make_req(8'h7F, 1'b0, 1'b1, 16'h1234));
    send_request(make_req(8'hAA, 1'b1, 1'b0, 16'h0000));
    send_request(make_req(8'h55, 1'b0, 1'b1, 16'hFFFF));
  endtask

  task automatic test_byte_outside_frame();
    send_request(make_req(8'hA5, 1'b0, 1'b1, 16'hFFFF));
    send_request(make_req(8'h5A, 1'b0, 1'b0, 16'h0000));
    drain_results();
    send_request(make_req(8'h3C, 1'b1, 1'b1, 16'd1));
  endtask

  task automatic test_abandoned_frame();
    send_request(make_req(8'h11, 1'b1, 1'b0, 16'd3));
    send_request(make_req(8'h22, 1'b0, 1'b0, 16'd0));
    send_request(make_req(8'h33, 1'b1, 1'b0, 16'd2));
    send_request(make_req(8'h44, 1'b0, 1'b1, 16'd0));
    send_request(make_req(8'h66, 1'b1, 1'b0, 16'd5));
    send_request(make_req(8'h77, 1'b1, 1'b1, 16'd1));
  endtask

  task automatic test_register_extremes();
    drain_results();
    write_reg(tfb_pkg::REG_PROTOCOL_VERSION, 8'h00);
    write_reg(tfb_pkg::REG_FRAME_TYPE, 8'hFF);
    send_frame(2, 16'd2, 1'b1);
    drain_results();
    write_reg(tfb_pkg::REG_PROTOCOL_VERSION, 8'hFF);
    write_reg(tfb_pkg::REG_FRAME_TYPE, 8'h00);
    send_frame(3, 16'd3, 1'b1);
    drain_results();
    write_reg(tfb_pkg::REG_PROTOCOL_VERSION, tfb_pkg::VERSION_RESET);
    write_reg(tfb_pkg::REG_FRAME_TYPE, tfb_pkg::TYPE_RESET);
  endtask

  task automatic test_backpressure();
    drain_results();
    rx_stall_on = 1'b0;
    tx_gaps_on = 1'b0;
    rx_hold_cycles = 200;
    send_frame(24, 16'd24, 1'b1);
    send_frame(1, 16'd1, 1'b1);
    // sender waits for the output to empty completely
    drain_results();
  endtask

  task automatic test_short_frames();
    rx_stall_on = 1'b1;
    tx_gaps_on = 1'b0;
    send_frame(2, 16'd2, 1'b1);
    send_frame(1, 16'd1, 1'b1);
    send_frame(3, 16'd3, 1'b1);
  endtask

  task automatic test_random_traffic();
    int unsigned start;
    int unsigned taken;
    int unsigned next_cfg_at;
    int unsigned n;
    int unsigned kind;
    start = requests_with_output;
    next_cfg_at = 120;
    taken = 0;
    while (taken < RANDOM_REQUESTS) begin
      if (taken >= QUIET_TAIL_START) begin
        rx_stall_on = 1'b0;
        tx_gaps_on = 1'b0;
      end else begin
        rx_stall_on = $urandom_range(0, 3) != 0;
        tx_gaps_on = $urandom_range(0, 3) != 0;
      end
      if (taken >= next_cfg_at && taken < QUIET_TAIL_START) begin
        drain_results();
        write_reg(tfb_pkg::REG_PROTOCOL_VERSION, 8'($urandom));
        write_reg(tfb_pkg::REG_FRAME_TYPE, 8'($urandom));
        next_cfg_at += 120;
      end
      kind = $urandom_range(0, 9);
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      case (kind)
        0: begin
          // noise: every field random, including the flags
          repeat ($urandom_range(1, 3)) send_request(tfb_pkg::in_item_t'(26'($urandom)));
        end
        1: send_frame(n, 16'($urandom), 1'b0);
        default: send_frame(n, ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'(n), 1'b1);
      endcase
      taken = requests_with_output - start;
    end
  endtask

  initial begin : run_tests
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = tfb_pkg::REG_PROTOCOL_VERSION;
    cfg_data = 8'h00;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_multi_byte_frame();
    test_byte_outside_frame();
    test_abandoned_frame();
    test_register_extremes();
    test_backpressure();
    test_short_frames();
    test_random_traffic();
    drain_results();

    if (mismatch_count == 0) begin
      $display("** telemetry_frame_builder_crc16: PASSED **");
    end else begin
      $display("** telemetry_frame_builder_crc16: FAILED **");
    end
    $finish;
  end

endmodule
